// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/otok_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Character codes, token kinds, limits and the types shared by the modules.
// ----------------------------------------------------------------------------
package otok_pkg;

  // Number of fraction digits that contribute to a float value (1 to 15).
  localparam int MAX_FRACTION_DIGITS = 10;
  // Identifier length saturates at this count (2 to 127).
  localparam int IDENT_LENGTH_LIMIT  = 80;
  // Result queue depth; a power of two, at least 4.
  localparam int FIFO_DEPTH          = 4;

  // Character codes.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_N     = 8'h6E;

  // Token kinds as seen on the result port.
  typedef enum logic [3:0] {
    KIND_INT     = 4'd0,
    KIND_FLOAT   = 4'd1,
    KIND_SLASH   = 4'd2,
    KIND_VERTEX  = 4'd3,
    KIND_TEXTURE = 4'd4,
    KIND_NORMAL  = 4'd5,
    KIND_FACE    = 4'd6,
    KIND_IDENT   = 4'd7,
    KIND_END     = 4'd8
  } kind_t;

  // One result transaction.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] int_value;
    logic signed [63:0] fixed_value;
    logic               last;
  } token_t;

  // Results written into the queue in one cycle: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

endpackage

// ===== sv/otok_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otok_fifo (
  input  logic             clk,
  input  logic             rst,
  input  otok_pkg::push_t  push,
  output logic             room,
  output otok_pkg::token_t head,
  output logic             out_valid,
  input  logic             out_ready
);

  localparam int PTR_W = $clog2(otok_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(otok_pkg::FIFO_DEPTH + 1);

  otok_pkg::token_t mem [otok_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  // Space for a full pair of results is required before a new item is processed.
  assign room      = (count <= CNT_W'(otok_pkg::FIFO_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  always_comb begin
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Storage writes; the second token goes to the slot after the first.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, count > CNT_W'(otok_pkg::FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_fifo_push_room, (push.count != 2'd0) |-> room, "push without room")
  `ASSERT_CLK(a_fifo_pop_only, (pop && push.count == 2'd0) |=> (count == $past(count) - CNT_W'(1)), "pop did not drain")

endmodule

// ===== sv/otok_lexer.sv =====
// ----------------------------------------------------------------------------
// Lexer step
// Input register, lexer state and the combinational step that produces tokens.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otok_lexer (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      text_byte,
  input  logic            end_of_input,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            room,
  output otok_pkg::push_t push
);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_INT     = 5'b00100,
    MODE_FRAC    = 5'b01000,
    MODE_IDENT   = 5'b10000
  } mode_t;

  localparam logic [6:0] LEN_LIMIT = 7'(otok_pkg::IDENT_LENGTH_LIMIT);
  localparam logic [3:0] FRAC_MAX  = 4'(otok_pkg::MAX_FRACTION_DIGITS);

  // Input register.
  logic       held;
  logic [7:0] byte_q;
  logic       eoi_q;
  logic       advance;

  // Lexer state.
  mode_t       mode, mode_next;
  logic        negative_flag, negative_flag_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  fraction_place, fraction_place_next;
  logic [7:0]  ident_first_char, ident_first_char_next;
  logic [7:0]  ident_second_char, ident_second_char_next;
  logic [6:0]  ident_length, ident_length_next;

  // Step control.
  logic             is_digit, is_letter, is_blank;
  logic [3:0]       digit;
  logic [3:0]       place;
  logic [35:0]      int_prod;
  logic             emit_pend, run_idle;
  logic             pend_valid;
  otok_pkg::token_t pend_tok;
  logic             second_valid;
  otok_pkg::token_t second_tok;
  logic             emit;
  logic [1:0]       n_results;

  // Rounded fraction steps: digit d at place p adds (d * 2^32 + 10^p / 2) / 10^p.
  logic [31:0] step_table [1:otok_pkg::MAX_FRACTION_DIGITS][10];

  for (genvar p = 1; p <= otok_pkg::MAX_FRACTION_DIGITS; p++) begin : g_place
    localparam logic [63:0] POW = 64'd10 ** p;
    for (genvar d = 0; d < 10; d++) begin : g_digit
      localparam logic [63:0] STEP = ((64'(d) << 32) + POW / 64'd2) / POW;
      assign step_table[p][d] = STEP[31:0];
    end
  end

  assign in_ready = !held || room;
  assign advance  = held && room;

  // Capture the incoming transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= text_byte;
      eoi_q  <= end_of_input;
    end
  end

  // Character classes.
  always_comb begin
    is_digit  = (byte_q >= otok_pkg::CHAR_ZERO) && (byte_q <= otok_pkg::CHAR_NINE);
    is_letter = (byte_q >= otok_pkg::CHAR_LOW_A) && (byte_q <= otok_pkg::CHAR_LOW_Z);
    is_blank  = (byte_q == otok_pkg::CHAR_SPACE) || (byte_q == otok_pkg::CHAR_LF) ||
                (byte_q == otok_pkg::CHAR_CR) || (byte_q == otok_pkg::CHAR_TAB);
    digit     = byte_q[3:0];
    place     = fraction_place + 4'd1;
    int_prod  = (36'(acc[31:0]) << 3) + (36'(acc[31:0]) << 1) + 36'(digit);
  end

  // The token that the current state would close.
  always_comb begin
    pend_tok   = '0;
    pend_valid = 1'b0;
    unique case (mode)
      MODE_INT: begin
        pend_valid         = 1'b1;
        pend_tok.kind      = otok_pkg::KIND_INT;
        if (negative_flag) begin
          pend_tok.int_value = -$signed(acc[31:0]);
        end else if (acc[31:0] > 32'h7FFF_FFFF) begin
          pend_tok.int_value = 32'sh7FFF_FFFF;
        end else begin
          pend_tok.int_value = $signed(acc[31:0]);
        end
      end
      MODE_FRAC: begin
        pend_valid    = 1'b1;
        pend_tok.kind = otok_pkg::KIND_FLOAT;
        if (negative_flag) begin
          pend_tok.fixed_value = acc[63] ? 64'sh8000_0000_0000_0000 : -$signed(acc);
        end else begin
          pend_tok.fixed_value = acc[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(acc);
        end
      end
      MODE_IDENT: begin
        pend_valid    = 1'b1;
        pend_tok.kind = otok_pkg::KIND_IDENT;
        if (ident_length == 7'd1 && ident_first_char == otok_pkg::CHAR_V) begin
          pend_tok.kind = otok_pkg::KIND_VERTEX;
        end else if (ident_length == 7'd1 && ident_first_char == otok_pkg::CHAR_F) begin
          pend_tok.kind = otok_pkg::KIND_FACE;
        end else if (ident_length == 7'd2 && ident_first_char == otok_pkg::CHAR_V &&
                     ident_second_char == otok_pkg::CHAR_T) begin
          pend_tok.kind = otok_pkg::KIND_TEXTURE;
        end else if (ident_length == 7'd2 && ident_first_char == otok_pkg::CHAR_V &&
                     ident_second_char == otok_pkg::CHAR_N) begin
          pend_tok.kind = otok_pkg::KIND_NORMAL;
        end
      end
      default: begin
        pend_valid = 1'b0;
      end
    endcase
  end

  // Next state and the token started or emitted by this byte.
  always_comb begin
    mode_next              = mode;
    negative_flag_next     = negative_flag;
    acc_next               = acc;
    fraction_place_next    = fraction_place;
    ident_first_char_next  = ident_first_char;
    ident_second_char_next = ident_second_char;
    ident_length_next      = ident_length;
    emit_pend              = 1'b0;
    run_idle               = 1'b0;
    second_valid           = 1'b0;
    second_tok             = '0;

    if (eoi_q) begin
      emit_pend          = 1'b1;
      second_valid       = 1'b1;
      second_tok.kind    = otok_pkg::KIND_END;
      mode_next          = MODE_IDLE;
      negative_flag_next = 1'b0;
      acc_next           = '0;
      fraction_place_next    = '0;
      ident_first_char_next  = '0;
      ident_second_char_next = '0;
      ident_length_next      = '0;
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          if (byte_q == otok_pkg::CHAR_LF) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            acc_next = (int_prod > 36'h8000_0000) ? 64'h8000_0000 : 64'(int_prod);
          end else if (byte_q == otok_pkg::CHAR_DOT) begin
            acc_next            = {acc[31:0], 32'h0};
            fraction_place_next = '0;
            mode_next           = MODE_FRAC;
          end else begin
            emit_pend = 1'b1;
            run_idle  = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            if (fraction_place < FRAC_MAX) begin
              fraction_place_next = place;
              acc_next            = acc + 64'(step_table[place][digit]);
            end
          end else begin
            emit_pend = 1'b1;
            run_idle  = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_letter) begin
            if (ident_length == 7'd1) begin
              ident_second_char_next = byte_q;
            end
            if (ident_length < LEN_LIMIT) begin
              ident_length_next = ident_length + 7'd1;
            end
          end else begin
            emit_pend = 1'b1;
            run_idle  = 1'b1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      // Between tokens: the byte may open a token or form one at once.
      if (run_idle) begin
        mode_next = MODE_IDLE;
        if (is_blank) begin
          mode_next = MODE_IDLE;
        end else if (byte_q == otok_pkg::CHAR_MINUS || is_digit) begin
          mode_next           = MODE_INT;
          negative_flag_next  = (byte_q == otok_pkg::CHAR_MINUS);
          acc_next            = (byte_q == otok_pkg::CHAR_MINUS) ? 64'h0 : 64'(digit);
          fraction_place_next = '0;
        end else if (byte_q == otok_pkg::CHAR_HASH) begin
          mode_next = MODE_COMMENT;
        end else if (byte_q == otok_pkg::CHAR_SLASH) begin
          second_valid    = 1'b1;
          second_tok.kind = otok_pkg::KIND_SLASH;
        end else if (is_letter) begin
          mode_next              = MODE_IDENT;
          ident_first_char_next  = byte_q;
          ident_second_char_next = '0;
          ident_length_next      = 7'd1;
        end else begin
          second_valid    = 1'b1;
          second_tok.kind = otok_pkg::KIND_IDENT;
        end
      end
    end
  end

  // Pack the results of this step in order, marking the final one.
  always_comb begin
    emit              = emit_pend && pend_valid;
    n_results         = 2'(emit) + 2'(second_valid);
    push              = '0;
    push.count        = advance ? n_results : 2'd0;
    push.first        = emit ? pend_tok : second_tok;
    push.first.last   = (n_results == 2'd1);
    push.second       = second_tok;
    push.second.last  = 1'b1;
  end

  // State update when the held item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      negative_flag     <= negative_flag_next;
      acc               <= acc_next;
      fraction_place    <= fraction_place_next;
      ident_first_char  <= ident_first_char_next;
      ident_second_char <= ident_second_char_next;
      ident_length      <= ident_length_next;
    end
  end

  `ASSERT_CLK(a_lex_eoi_result, (advance && eoi_q) |-> (push.count != 2'd0), "end of input gave no result")
  `ASSERT_CLK(a_lex_eoi_idle, (advance && eoi_q) |=> (mode == MODE_IDLE), "lexer not idle after end of input")
  `ASSERT_CLK(a_lex_pair_order, (push.count == 2'd2) |-> (!push.first.last && push.second.last), "bad last marking on result pair")

endmodule

// ===== sv/obj_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Geometry text tokenizer
// Streaming lexer that turns a byte stream into integer, float, slash,
// keyword, identifier and end tokens.
// ----------------------------------------------------------------------------
// One byte (or an end-of-input mark) is taken per transaction, and a new byte
// can be taken every cycle: each byte passes through an input register and a
// combinational lexer step whose results enter a four-entry result queue. A
// byte yields zero, one or two result transactions, the final one flagged by
// last_result; a byte is only processed while the queue has room for two
// results, so a sustained rate of one byte per cycle holds whenever each byte
// gives at most one result and the result side takes one per cycle. The input
// register and the result queue lie between input and first result.

module obj_text_tokenizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         text_byte,
  input  logic               end_of_input,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [3:0]         token_kind,
  output logic signed [31:0] int_value,
  output logic signed [63:0] fixed_value,
  output logic               last_result,
  output logic               out_valid,
  input  logic               out_ready
);

  otok_pkg::push_t  push;
  otok_pkg::token_t head;
  logic             room;

  otok_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .end_of_input (end_of_input),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .room         (room),
    .push         (push)
  );

  otok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .head      (head),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // Result fields come straight from the queue head.
  assign token_kind  = head.kind;
  assign int_value   = head.int_value;
  assign fixed_value = head.fixed_value;
  assign last_result = head.last;

endmodule
